### design/qrs_pkg.sv
package qrs_pkg;

  // Depth of the queue between the front end and the root pipeline.
  localparam int unsigned QDepthDef = 2;

  localparam int unsigned SqrtSteps = 17;  // one root bit per stage, 34-bit radicand
  localparam int unsigned DivSteps  = 25;  // one quotient bit per stage
  localparam int unsigned PrepStg   = 0;
  localparam int unsigned NumStg    = SqrtSteps + 1;
  localparam int unsigned NStages   = SqrtSteps + DivSteps + 2;

  localparam logic [1:0] CntNone = 2'd0;
  localparam logic [1:0] CntOne  = 2'd1;
  localparam logic [1:0] CntTwo  = 2'd2;

  // Word handed from the front end to the back end.
  typedef struct packed {
    logic               up;
    logic               degen;
    logic               a_neg;
    logic signed [15:0] b;
    logic signed [31:0] bb;
    logic signed [31:0] ac;
    logic [16:0]        den;
  } fb_t;

  // Word carried through every stage of the back end.
  typedef struct packed {
    logic               up;
    logic               degen;
    logic               a_neg;
    logic [1:0]         cnt;
    logic signed [15:0] b;
    logic signed [31:0] bb;
    logic signed [31:0] ac;
    logic [16:0]        den;
    logic [33:0]        rad;
    logic [17:0]        srem;
    logic [16:0]        root;
    logic [24:0]        np_mag;
    logic [24:0]        nm_mag;
    logic               neg_p;
    logic               neg_m;
    logic [24:0]        qp;
    logic [24:0]        qm;
    logic [17:0]        remp;
    logic [17:0]        remm;
  } st_t;

  // Discriminant, root count and radicand.
  function automatic st_t prep_step(st_t s);
    st_t o;
    logic signed [33:0] disc;
    o = s;
    disc = $signed({{2{s.bb[31]}}, s.bb}) - $signed({s.ac, 2'b00});
    if (s.degen || disc[33]) begin
      o.cnt = CntNone;
    end else if (disc == '0) begin
      o.cnt = CntOne;
    end else begin
      o.cnt = CntTwo;
    end
    o.rad  = (s.degen || disc[33]) ? '0 : disc;
    o.srem = '0;
    o.root = '0;
    return o;
  endfunction

  // One digit-by-digit square root step.
  function automatic st_t sqrt_step(st_t s);
    st_t o;
    logic [19:0] r2;
    logic [19:0] trial;
    o = s;
    r2    = {s.srem, s.rad[33:32]};
    trial = {1'b0, s.root, 2'b01};
    if (r2 >= trial) begin
      o.srem = 18'(r2 - trial);
      o.root = {s.root[15:0], 1'b1};
    end else begin
      o.srem = r2[17:0];
      o.root = {s.root[15:0], 1'b0};
    end
    o.rad = {s.rad[31:0], 2'b00};
    return o;
  endfunction

  // Numerators -b +/- s as magnitudes scaled by 256, with quotient signs.
  function automatic st_t num_step(st_t s);
    st_t o;
    logic signed [18:0] nb;
    logic signed [18:0] np;
    logic signed [18:0] nm;
    logic [18:0]        ap;
    logic [18:0]        am;
    o = s;
    nb = -$signed({{3{s.b[15]}}, s.b});
    np = nb + $signed({2'b00, s.root});
    nm = nb - $signed({2'b00, s.root});
    ap = np[18] ? 19'(-np) : np;
    am = nm[18] ? 19'(-nm) : nm;
    o.np_mag = {ap[16:0], 8'h00};
    o.nm_mag = {am[16:0], 8'h00};
    o.neg_p  = np[18] ^ s.a_neg;
    o.neg_m  = nm[18] ^ s.a_neg;
    o.qp     = '0;
    o.qm     = '0;
    o.remp   = '0;
    o.remm   = '0;
    return o;
  endfunction

  // One restoring division step for both roots.
  function automatic st_t div_step(st_t s);
    st_t o;
    logic [17:0] rp2;
    logic [17:0] rm2;
    o = s;
    rp2 = {s.remp[16:0], s.np_mag[24]};
    rm2 = {s.remm[16:0], s.nm_mag[24]};
    if (rp2 >= {1'b0, s.den}) begin
      o.remp = rp2 - {1'b0, s.den};
      o.qp   = {s.qp[23:0], 1'b1};
    end else begin
      o.remp = rp2;
      o.qp   = {s.qp[23:0], 1'b0};
    end
    if (rm2 >= {1'b0, s.den}) begin
      o.remm = rm2 - {1'b0, s.den};
      o.qm   = {s.qm[23:0], 1'b1};
    end else begin
      o.remm = rm2;
      o.qm   = {s.qm[23:0], 1'b0};
    end
    o.np_mag = {s.np_mag[23:0], 1'b0};
    o.nm_mag = {s.nm_mag[23:0], 1'b0};
    return o;
  endfunction

endpackage

### design/qrs_if.sv
interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;

  modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic               opens_upward;
  logic [1:0]         root_count;
  logic signed [31:0] root_plus;
  logic signed [31:0] root_minus;
  logic               degenerate;

  modport source(output valid, output opens_upward, output root_count, output root_plus,
                 output root_minus, output degenerate, input ready);
  modport sink(input valid, input opens_upward, input root_count, input root_plus,
               input root_minus, input degenerate, output ready);
endinterface

### design/qrs_front.sv
module qrs_front (
  input  logic           clk,
  input  logic           rst_n,
  qrs_in_if.sink         in_ch,
  output logic           fr_valid,
  input  logic           fr_ready,
  output qrs_pkg::fb_t   fr_word
);
  import qrs_pkg::*;

  logic v_r;
  fb_t  w_r;
  fb_t  w_nxt;
  logic [16:0] a_abs;

  assign in_ch.ready = !v_r || fr_ready;
  assign fr_valid    = v_r;
  assign fr_word     = w_r;

  // Classify a and form the two products.
  always_comb begin
    a_abs       = in_ch.coef_a[15] ? 17'(-$signed({in_ch.coef_a[15], in_ch.coef_a}))
                                   : {1'b0, in_ch.coef_a};
    w_nxt.up    = !in_ch.coef_a[15] && (in_ch.coef_a != '0);
    w_nxt.degen = (in_ch.coef_a == '0);
    w_nxt.a_neg = in_ch.coef_a[15];
    w_nxt.b     = in_ch.coef_b;
    w_nxt.bb    = 32'(in_ch.coef_b * in_ch.coef_b);
    w_nxt.ac    = 32'(in_ch.coef_a * in_ch.coef_c);
    w_nxt.den   = {a_abs[15:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      w_r <= w_nxt;
    end
  end

endmodule

### design/qrs_queue.sv
module qrs_queue #(
  parameter int unsigned Depth = qrs_pkg::QDepthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  qrs_pkg::fb_t push_word,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output qrs_pkg::fb_t head
);
  import qrs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fb_t             mem_r [Depth];
  logic [PtrW-1:0] wr_r;
  logic [PtrW-1:0] rd_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(do_push) - CntW'(do_pop);
    end
    if (do_push) begin
      mem_r[wr_r] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth)) else $error("queue count above depth");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> full) else $error("queue left full without a read");
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !push |=> empty) else $error("queue gained a word without a write");

endmodule

### design/qrs_back.sv
module qrs_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  qrs_pkg::fb_t q_head,
  output logic         q_pop,
  qrs_out_if.source    out_ch
);
  import qrs_pkg::*;

  logic v_r   [NStages];
  st_t  st_r  [NStages];
  st_t  st_nxt[NStages];
  st_t  head_st;
  logic en;
  logic out_v_r;
  logic               up_r;
  logic [1:0]         cnt_r;
  logic signed [31:0] rp_r;
  logic signed [31:0] rm_r;
  logic               degen_r;
  logic signed [31:0] qp32;
  logic signed [31:0] qm32;

  // The whole pipeline moves together whenever the output register can take a word.
  assign en    = !out_v_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    head_st       = '0;
    head_st.up    = q_head.up;
    head_st.degen = q_head.degen;
    head_st.a_neg = q_head.a_neg;
    head_st.b     = q_head.b;
    head_st.bb    = q_head.bb;
    head_st.ac    = q_head.ac;
    head_st.den   = q_head.den;
    st_nxt[PrepStg] = prep_step(head_st);
    for (int k = 1; k < NStages; k++) begin
      if (k <= SqrtSteps) begin
        st_nxt[k] = sqrt_step(st_r[k-1]);
      end else if (k == NumStg) begin
        st_nxt[k] = num_step(st_r[k-1]);
      end else begin
        st_nxt[k] = div_step(st_r[k-1]);
      end
    end
  end

  always_comb begin
    qp32 = $signed({7'b0, st_r[NStages-1].qp});
    qm32 = $signed({7'b0, st_r[NStages-1].qm});
    if (st_r[NStages-1].neg_p) begin
      qp32 = -qp32;
    end
    if (st_r[NStages-1].neg_m) begin
      qm32 = -qm32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NStages; k++) begin
        v_r[k] <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= !q_empty;
      for (int k = 1; k < NStages; k++) begin
        v_r[k] <= v_r[k-1];
      end
      out_v_r <= v_r[NStages-1];
    end
    if (en) begin
      for (int k = 0; k < NStages; k++) begin
        st_r[k] <= st_nxt[k];
      end
      up_r    <= st_r[NStages-1].up;
      cnt_r   <= st_r[NStages-1].cnt;
      degen_r <= st_r[NStages-1].degen;
      rp_r    <= (st_r[NStages-1].cnt == CntNone) ? '0 : qp32;
      rm_r    <= (st_r[NStages-1].cnt == CntTwo) ? qm32 : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.opens_upward = up_r;
  assign out_ch.root_count   = cnt_r;
  assign out_ch.root_plus    = rp_r;
  assign out_ch.root_minus   = rm_r;
  assign out_ch.degenerate   = degen_r;

  a_degen_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && degen_r |-> cnt_r == CntNone && !up_r)
    else $error("degenerate word carries roots");
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> cnt_r != 2'd3) else $error("illegal root count");
  a_minus_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && cnt_r != CntTwo |-> rm_r == '0 && (cnt_r != CntNone || rp_r == '0))
    else $error("root field set without matching root count");

endmodule

### design/quadratic_root_solver.sv
// Quadratic root solver for a*x^2 + b*x + c with signed Q8.8 coefficients.
// The input channel (in_ch) moves one word of coef_a, coef_b and coef_c; the
// output channel (out_ch) moves one word per input word with opens_upward,
// root_count, root_plus, root_minus (signed Q24.8, truncated toward zero)
// and degenerate. Both channels use valid/ready; a word moves on a clock
// edge where both are high.
// The front end registers b*b and a*c and classifies a. A short queue then
// feeds the back end: one stage forms the discriminant, 17 stages take the
// floor square root one bit each, one stage forms the numerators, and 25
// stages divide both roots at once, one quotient bit each, into an output
// register. One word is accepted every cycle while the output is not stalled.
// When the receiver stalls, the back end holds in place and the queue and
// the front register keep taking words until they fill, then in_ch.ready
// drops. A synchronous active-low reset empties every stage and the queue;
// no word is in flight after it. When a is zero, degenerate is set and
// both roots read as zero.
module quadratic_root_solver #(
  parameter int unsigned QDepth = qrs_pkg::QDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  qrs_in_if.sink     in_ch,
  qrs_out_if.source  out_ch
);
  import qrs_pkg::*;

  logic fr_valid;
  logic q_full;
  logic q_empty;
  logic q_pop;
  fb_t  fr_word;
  fb_t  q_head;

  // Front end: products and classification of a.
  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fr_valid (fr_valid),
    .fr_ready (!q_full),
    .fr_word  (fr_word)
  );

  // Queue that lets the front and back stall independently.
  qrs_queue #(.Depth(QDepth)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .push_word (fr_word),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end: discriminant, square root and the two divisions.
  qrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### dv/qrs_tb_if.sv
`timescale 1ns / 1ps
// Interfaces come from design/qrs_if.sv; this file holds the word types the bench exchanges.
package qrs_tb_pkg;

  typedef struct {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
  } coef_word_t;

  typedef struct {
    logic               opens_upward;
    logic [1:0]         root_count;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic               degenerate;
  } root_word_t;

endpackage

### dv/tb_quadratic_root_solver.sv
`timescale 1ns / 1ps
module tb_quadratic_root_solver;
  import qrs_pkg::*;
  import qrs_tb_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int DrainCycles = 60;

  logic clk;
  logic rst_n;

  qrs_in_if  in_ch();
  qrs_out_if out_ch();

  quadratic_root_solver u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Expected root words, oldest first, and the running error count.
  root_word_t expected_roots[$];
  int         error_count;
  int         cycle_count;
  // When set, both sides run without any random idling.
  bit         no_idle;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Floor integer square root of a non-negative discriminant.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Compute the roots word the solver must return for one coefficient word.
  function automatic root_word_t solve_roots(coef_word_t w);
    root_word_t r;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint s;
    longint den;
    a = w.coef_a;
    b = w.coef_b;
    c = w.coef_c;
    disc = b * b - 4 * a * c;
    r.opens_upward = (a > 0);
    r.root_count = CntNone;
    r.root_plus = '0;
    r.root_minus = '0;
    r.degenerate = (a == 0);
    if (a != 0 && disc >= 0) begin
      s = longint'(floor_sqrt(longint'(disc)));
      den = 2 * a;
      // SystemVerilog integer division truncates toward zero, as required.
      r.root_plus = 32'((( -b + s) * 256) / den);
      if (disc > 0) begin
        r.root_minus = 32'(((-b - s) * 256) / den);
        r.root_count = CntTwo;
      end else begin
        r.root_count = CntOne;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR: %s mismatch at cycle %0d: got %0d, expected %0d",
             what, cycle_count, got, want);
    error_count++;
  endtask

  // Random idle decision: true with a chance of 24 in a hundred, unless idling is off.
  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 24);
  endfunction

  // Send one coefficient word and queue its expected roots on acceptance.
  // Called at a falling edge; valid stays high afterwards so that words can
  // follow back to back, and it drops on an idle cycle or when draining.
  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    coef_word_t w;
    w.coef_a = a;
    w.coef_b = b;
    w.coef_c = c;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.coef_a <= a;
    in_ch.coef_b <= b;
    in_ch.coef_c <= c;
    do @(posedge clk); while (!in_ch.ready);
    expected_roots.push_back(solve_roots(w));
    @(negedge clk);
  endtask

  // Receiver: stall at random and check each accepted word against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= !idle_now();
  end

  always @(posedge clk) begin
    root_word_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_roots.pop_front();
        if (out_ch.opens_upward !== want.opens_upward)
          report_mismatch("opens_upward", out_ch.opens_upward, want.opens_upward);
        if (out_ch.root_count !== want.root_count)
          report_mismatch("root_count", out_ch.root_count, want.root_count);
        if (out_ch.root_plus !== want.root_plus)
          report_mismatch("root_plus", out_ch.root_plus, want.root_plus);
        if (out_ch.root_minus !== want.root_minus)
          report_mismatch("root_minus", out_ch.root_minus, want.root_minus);
        if (out_ch.degenerate !== want.degenerate)
          report_mismatch("degenerate", out_ch.degenerate, want.degenerate);
      end
    end
    if (cycle_count > MaxCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Extremes of every coefficient plus each special case: a of zero, a
  // negative discriminant, a zero discriminant and a negative a.
  task automatic test_directed();
    send_coefs(16'sd0, 16'sd100, 16'sd5);
    send_coefs(16'sd0, 16'sd0, 16'sd0);
    send_coefs(16'sd256, 16'sd0, 16'sd256);
    send_coefs(16'sd256, -16'sd512, 16'sd256);
    send_coefs(16'sd256, 16'sd0, -16'sd1024);
    send_coefs(-16'sd256, 16'sd256, 16'sd512);
    send_coefs(-16'sd32768, -16'sd32768, 16'sd32767);
    send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
    send_coefs(16'sd1, -16'sd32768, 16'sd0);
    send_coefs(-16'sd1, 16'sd32767, 16'sd0);
    send_coefs(16'sd1, 16'sd32767, -16'sd32768);
    send_coefs(-16'sd32768, 16'sd32767, 16'sd32767);
    send_coefs(16'sd1, 16'sd2, 16'sd1);
    send_coefs(-16'sd1, -16'sd1, -16'sd1);
    send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
    send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
  endtask

  // Random words: mostly uniform, some with a of zero, small a, or a of 32767 or -1 with c
  // negated, and some built around perfect squares so that zero discriminants come up often.
  task automatic test_random(int count);
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      a = 16'($urandom());
      b = 16'($urandom());
      c = 16'($urandom());
      case ($urandom_range(9))
        0: a = '0;
        1: a = $signed(16'($urandom_range(8))) - 16'sd4;
        2: begin
          // b = 2k, a = 1, c = k*k gives a zero discriminant.
          k = $urandom_range(180);
          a = 16'sd1;
          b = 16'(2 * k);
          c = 16'(k * k);
        end
        3: begin
          a = 16'sd32767 ^ 16'($urandom_range(1) << 15);
          c = -c;
        end
        default: ;
      endcase
      send_coefs(a, b, c);
    end
  endtask

  // Hold the sender until every expected word has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk);
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    wait_for_drain();
    test_random(500);
    // A stretch with no idling on either side keeps the pipeline full.
    no_idle = 1'b1;
    test_random(400);
    no_idle = 1'b0;
    test_random(500);
    wait_for_drain();
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
